// ===== hdl/fpcs_pkg.sv =====
// Package with the types, constants and arithmetic helpers of the four-point subdivision block.
package fpcs_pkg;

    localparam int COORD_BITS = 32;
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int MIX_BITS   = COORD_BITS + 6;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef logic signed [MIX_BITS-1:0]   t_mix;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               final_vertex;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               inserted;
        logic               final_point;
    } t_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_sum x;
        t_sum y;
        t_sum z;
    } t_sums;

    typedef struct packed {
        t_mix x;
        t_mix y;
        t_mix z;
    } t_mixes;

    // Echo emits the current vertex, pair emits the held and current vertex,
    // split emits the older held vertex and the inserted point, plus the tail on the last vertex.
    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_PAIR,
        CMD_SPLIT
    } t_cmd;

    typedef struct packed {
        t_cmd   cmd;
        logic   last;
        t_point p1;
        t_point p2;
        t_point p3;
        t_sums  bc;
        t_sums  ad;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_req;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic t_mix mix9(input t_sum bc, input t_sum ad);
        t_mix e;
        t_mix f;
        e = t_mix'(bc);
        f = t_mix'(ad);
        return (e <<< 3) + e - f;
    endfunction

    function automatic t_coord sat_div16(input t_mix q);
        logic [COORD_BITS+1:0] sh;
        sh = q[MIX_BITS-1:4];
        if (sh[COORD_BITS+1:COORD_BITS-1] == '0 || sh[COORD_BITS+1:COORD_BITS-1] == '1) begin
            return t_coord'(sh[COORD_BITS-1:0]);
        end else if (sh[COORD_BITS+1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

endpackage

// ===== hdl/fpcs_front.sv =====
// Front part: holds the vertex window and count and turns each vertex that yields points into a command.
module fpcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fpcs_pkg::t_in i_data,
    input  logic          i_q_full,
    output fpcs_pkg::t_req o_req
);

    fpcs_pkg::t_point r_w0, r_w1, r_w2;
    logic [1:0]       r_seen;
    logic [1:0]       n_seen;
    fpcs_pkg::t_point cur;
    logic             accept;
    logic             last;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign last    = i_data.final_vertex;
    assign cur.x   = fpcs_pkg::t_coord'(i_data.coord_x);
    assign cur.y   = fpcs_pkg::t_coord'(i_data.coord_y);
    assign cur.z   = fpcs_pkg::t_coord'(i_data.coord_z);

    always_comb begin
        o_req.valid       = 1'b0;
        o_req.entry.cmd   = fpcs_pkg::CMD_ECHO;
        o_req.entry.last  = last;
        o_req.entry.p1    = r_w1;
        o_req.entry.p2    = r_w2;
        o_req.entry.p3    = cur;
        o_req.entry.bc.x  = fpcs_pkg::t_sum'(r_w1.x) + fpcs_pkg::t_sum'(r_w2.x);
        o_req.entry.bc.y  = fpcs_pkg::t_sum'(r_w1.y) + fpcs_pkg::t_sum'(r_w2.y);
        o_req.entry.bc.z  = fpcs_pkg::t_sum'(r_w1.z) + fpcs_pkg::t_sum'(r_w2.z);
        o_req.entry.ad.x  = fpcs_pkg::t_sum'(r_w0.x) + fpcs_pkg::t_sum'(cur.x);
        o_req.entry.ad.y  = fpcs_pkg::t_sum'(r_w0.y) + fpcs_pkg::t_sum'(cur.y);
        o_req.entry.ad.z  = fpcs_pkg::t_sum'(r_w0.z) + fpcs_pkg::t_sum'(cur.z);
        n_seen            = r_seen;
        case (r_seen)
            2'd0: begin
                o_req.valid = accept;
            end
            2'd1: begin
                o_req.valid = accept && last;
            end
            2'd2: begin
                o_req.valid     = accept && last;
                o_req.entry.cmd = fpcs_pkg::CMD_PAIR;
            end
            default: begin
                o_req.valid     = accept;
                o_req.entry.cmd = fpcs_pkg::CMD_SPLIT;
            end
        endcase
        if (last) begin
            n_seen = 2'd0;
        end else if (r_seen != 2'd3) begin
            n_seen = r_seen + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
        end else if (accept) begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= cur;
        end
    end

endmodule

// ===== hdl/fpcs_queue.sv =====
// Short command queue between the front and back parts.
module fpcs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpcs_pkg::t_req   i_req,
    output logic             o_full,
    output fpcs_pkg::t_req   o_head,
    input  logic             i_pop
);

    fpcs_pkg::t_entry                  r_ent [fpcs_pkg::Q_DEPTH];
    logic [fpcs_pkg::Q_PTR_BITS-1:0]   r_wr, r_rd;
    logic [fpcs_pkg::Q_CNT_BITS-1:0]   r_cnt;
    logic                              push;
    logic                              pop;

    assign o_full       = (r_cnt == fpcs_pkg::Q_CNT_BITS'(fpcs_pkg::Q_DEPTH));
    assign push         = i_req.valid && !o_full;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + fpcs_pkg::Q_PTR_BITS'(1);
            end
            if (pop) begin
                r_rd <= r_rd + fpcs_pkg::Q_PTR_BITS'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + fpcs_pkg::Q_CNT_BITS'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - fpcs_pkg::Q_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= i_req.entry;
        end
    end

endmodule

// ===== hdl/fpcs_back.sv =====
// Back part: steps through each command, computes inserted points and drives the output register.
module fpcs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpcs_pkg::t_req   i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output fpcs_pkg::t_out   o_data
);

    logic [1:0]             r_step;
    logic                   r_ov;
    fpcs_pkg::t_out         r_out;
    fpcs_pkg::t_mixes       r_q;
    fpcs_pkg::t_out         n_out;
    logic [1:0]             last_step;
    logic                   adv;
    fpcs_pkg::t_entry       ent;

    assign ent     = i_head.entry;
    assign adv     = i_head.valid && (!r_ov || i_ready);
    assign o_pop   = adv && (r_step == last_step);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        n_out.out_x       = ent.p3.x;
        n_out.out_y       = ent.p3.y;
        n_out.out_z       = ent.p3.z;
        n_out.inserted    = 1'b0;
        n_out.final_point = 1'b0;
        last_step         = 2'd0;
        case (ent.cmd)
            fpcs_pkg::CMD_ECHO: begin
                n_out.final_point = ent.last;
            end
            fpcs_pkg::CMD_PAIR: begin
                last_step = 2'd1;
                if (r_step == 2'd0) begin
                    n_out.out_x = ent.p2.x;
                    n_out.out_y = ent.p2.y;
                    n_out.out_z = ent.p2.z;
                end else begin
                    n_out.final_point = 1'b1;
                end
            end
            fpcs_pkg::CMD_SPLIT: begin
                last_step = ent.last ? 2'd3 : 2'd1;
                case (r_step)
                    2'd0: begin
                        n_out.out_x = ent.p1.x;
                        n_out.out_y = ent.p1.y;
                        n_out.out_z = ent.p1.z;
                    end
                    2'd1: begin
                        n_out.out_x    = fpcs_pkg::sat_div16(r_q.x);
                        n_out.out_y    = fpcs_pkg::sat_div16(r_q.y);
                        n_out.out_z    = fpcs_pkg::sat_div16(r_q.z);
                        n_out.inserted = 1'b1;
                    end
                    2'd2: begin
                        n_out.out_x = ent.p2.x;
                        n_out.out_y = ent.p2.y;
                        n_out.out_z = ent.p2.z;
                    end
                    default: begin
                        n_out.final_point = 1'b1;
                    end
                endcase
            end
            default: begin
                last_step = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (adv) begin
                r_step <= (r_step == last_step) ? 2'd0 : r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
        if (adv && r_step == 2'd0) begin
            r_q.x <= fpcs_pkg::mix9(ent.bc.x, ent.ad.x);
            r_q.y <= fpcs_pkg::mix9(ent.bc.y, ent.ad.y);
            r_q.z <= fpcs_pkg::mix9(ent.bc.z, ent.ad.z);
        end
    end

endmodule

// ===== hdl/four_point_curve_subdivision.sv =====
// Top level of the streaming four-point curve subdivision block.
//
// Vertices enter on the input channel (i_valid, o_ready, i_data) and points
// leave on the output channel (o_valid, i_ready, o_data); a transfer happens
// when valid and ready are both high at a rising edge of i_clk.
// The front part keeps the last three vertices and a vertex count and turns each
// vertex that yields points into a command; a two-entry command queue feeds the
// back part, which emits one point per cycle through an output register while the receiver is ready.
// With the back part idle, the command of a vertex is written into the queue and
// its first point then into the output register, where o_valid rises for it.
// A vertex from the fourth on yields two points and the last vertex of a long
// polyline yields four, all through the single output port; a vertex that yields
// no point puts no command into the queue.
// The front accepts vertices while the queue has room, so it keeps taking input
// while a finished point waits in the output register.
// When the receiver stalls, the output register holds its point, the back part
// stops and the queue fills, after which o_ready falls.
// A synchronous active-low reset on i_rst_n empties the queue and output register
// and starts a new polyline.
module four_point_curve_subdivision (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fpcs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output fpcs_pkg::t_out o_data
);

    fpcs_pkg::t_req req;
    fpcs_pkg::t_req head;
    logic           q_full;
    logic           pop;

    fpcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_req    (req)
    );

    fpcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    fpcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== test/four_point_curve_subdivision_test.sv =====
// Self-checking testbench for the four-point curve subdivision block.
module four_point_curve_subdivision_test;

    localparam int RANDOM_VERTICES = 150;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        fpcs_pkg::t_in  vin;
        bit             typed;
        fpcs_pkg::t_out want;
    } t_stim_row;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_ready = 1'b0;
    fpcs_pkg::t_in   i_data  = '0;
    logic            o_ready;
    logic            o_valid;
    fpcs_pkg::t_out  o_data;

    fpcs_pkg::t_point held_pts[3] = '{default: '0};
    logic [1:0]       verts_seen = 2'd0;
    fpcs_pkg::t_out   expected_points[$];
    t_stim_row        directed_rows[$];

    bit  hold_off_req = 1'b0;
    int  send_calm    = 0;
    int  failures     = 0;
    int  cycle_count  = 0;
    int  vertices_sent = 0;
    int  polylines_sent = 0;
    int  points_seen  = 0;
    int  inserted_seen = 0;
    int  saturated_seen = 0;

    four_point_curve_subdivision DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d points outstanding.",
                     cycle_count, expected_points.size());
            $display("four_point_curve_subdivision_test: FAIL");
            $finish;
        end
    end

    function automatic fpcs_pkg::t_out make_point(input fpcs_pkg::t_point p, input logic ins,
                                                  input logic fin);
        fpcs_pkg::t_out pt;
        pt.out_x       = p.x;
        pt.out_y       = p.y;
        pt.out_z       = p.z;
        pt.inserted    = ins;
        pt.final_point = fin;
        return pt;
    endfunction

    function automatic fpcs_pkg::t_coord split_coord(input fpcs_pkg::t_coord a, b, c, d);
        longint acc;
        acc = (9 * (longint'(b) + longint'(c)) - (longint'(a) + longint'(d))) >>> 4;
        if (acc > longint'(fpcs_pkg::COORD_MAX)) begin
            return fpcs_pkg::COORD_MAX;
        end
        if (acc < longint'(fpcs_pkg::COORD_MIN)) begin
            return fpcs_pkg::COORD_MIN;
        end
        return fpcs_pkg::t_coord'(acc);
    endfunction

    function automatic void predict_vertex(input fpcs_pkg::t_in v, input bit typed,
                                           input fpcs_pkg::t_out want);
        fpcs_pkg::t_point cur;
        fpcs_pkg::t_point mid;
        fpcs_pkg::t_out   pts[$];
        cur.x = v.coord_x;
        cur.y = v.coord_y;
        cur.z = v.coord_z;
        if (verts_seen == 2'd0) begin
            pts = {pts, make_point(cur, 1'b0, v.final_vertex)};
        end else if (verts_seen < 2'd3) begin
            if (v.final_vertex) begin
                if (verts_seen == 2'd2) begin
                    pts = {pts, make_point(held_pts[2], 1'b0, 1'b0)};
                end
                pts = {pts, make_point(cur, 1'b0, 1'b1)};
            end
        end else begin
            mid.x = split_coord(held_pts[0].x, held_pts[1].x, held_pts[2].x, cur.x);
            mid.y = split_coord(held_pts[0].y, held_pts[1].y, held_pts[2].y, cur.y);
            mid.z = split_coord(held_pts[0].z, held_pts[1].z, held_pts[2].z, cur.z);
            pts = {pts, make_point(held_pts[1], 1'b0, 1'b0)};
            pts = {pts, make_point(mid, 1'b1, 1'b0)};
            if (v.final_vertex) begin
                pts = {pts, make_point(held_pts[2], 1'b0, 1'b0)};
                pts = {pts, make_point(cur, 1'b0, 1'b1)};
            end
        end
        held_pts[0] = held_pts[1];
        held_pts[1] = held_pts[2];
        held_pts[2] = cur;
        if (v.final_vertex) begin
            verts_seen = 2'd0;
        end else if (verts_seen < 2'd3) begin
            verts_seen++;
        end
        if (typed) begin
            expected_points = {expected_points, want};
        end else begin
            foreach (pts[k]) begin
                expected_points = {expected_points, pts[k]};
            end
        end
    endfunction

    function automatic void add_row(input fpcs_pkg::t_coord x, y, z, input logic last,
                                    input bit typed);
        t_stim_row        row;
        fpcs_pkg::t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        row.vin.coord_x      = x;
        row.vin.coord_y      = y;
        row.vin.coord_z      = z;
        row.vin.final_vertex = last;
        row.typed            = typed;
        row.want             = make_point(p, 1'b0, last);
        directed_rows        = {directed_rows, row};
    endfunction

    function automatic fpcs_pkg::t_coord random_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return fpcs_pkg::t_coord'($urandom);
        end else if (r < 75) begin
            return fpcs_pkg::t_coord'(int'($urandom_range(0, 1048575)) - 524288);
        end else if (r < 83) begin
            return fpcs_pkg::COORD_MAX - fpcs_pkg::t_coord'($urandom_range(0, 255));
        end else if (r < 91) begin
            return fpcs_pkg::COORD_MIN + fpcs_pkg::t_coord'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0: return fpcs_pkg::COORD_MAX;
            1: return fpcs_pkg::COORD_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 92) begin
            send_calm = $urandom_range(20, 50);
            return 0;
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 1;
        end else if (r < 16) begin
            return 2;
        end else if (r < 24) begin
            return 3;
        end
        return $urandom_range(4, 14);
    endfunction

    task automatic send_vertex(input fpcs_pkg::t_in v, input bit typed,
                               input fpcs_pkg::t_out want);
        i_valid <= 1'b1;
        i_data  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_vertex(v, typed, want);
        vertices_sent++;
        if (v.final_vertex) begin
            polylines_sent++;
        end
    endtask

    task automatic idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_sender();
        i_valid <= 1'b0;
        wait (expected_points.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin : receiver
        int  hold_left;
        int  stall_left;
        int  calm_left;
        int  r;
        logic nxt;
        hold_left  = 0;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES - 1;
                nxt          = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                nxt = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                nxt = 1'b1;
                if (r < 20) begin
                    nxt        = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 27) begin
                    calm_left = $urandom_range(20, 60);
                end else if (r < 30) begin
                    nxt        = 1'b0;
                    stall_left = $urandom_range(10, 30);
                end
            end
            i_ready <= nxt;
        end
    end

    always @(posedge i_clk) begin : check_points
        fpcs_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            points_seen++;
            if (o_data.inserted) begin
                inserted_seen++;
                if (o_data.out_x == fpcs_pkg::COORD_MAX ||
                    o_data.out_x == fpcs_pkg::COORD_MIN) begin
                    saturated_seen++;
                end
            end
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("Unexpected point at cycle %0d: x=%h y=%h z=%h ins=%b fin=%b",
                             cycle_count, o_data.out_x, o_data.out_y, o_data.out_z,
                             o_data.inserted, o_data.final_point);
                end
            end else begin
                want = expected_points.pop_front();
                if (o_data.out_x !== want.out_x || o_data.out_y !== want.out_y ||
                    o_data.out_z !== want.out_z || o_data.inserted !== want.inserted ||
                    o_data.final_point !== want.final_point) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("Point mismatch at cycle %0d", cycle_count);
                        $display("  expected x=%h y=%h z=%h ins=%b fin=%b",
                                 want.out_x, want.out_y, want.out_z,
                                 want.inserted, want.final_point);
                        $display("  actual   x=%h y=%h z=%h ins=%b fin=%b",
                                 o_data.out_x, o_data.out_y, o_data.out_z,
                                 o_data.inserted, o_data.final_point);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        fpcs_pkg::t_in v;
        int            random_sent;
        int            len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b1, 1'b1);
        add_row(fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MAX, 1'b1, 1'b1);
        add_row(fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MIN, 1'b1, 1'b1);
        add_row(32'sd0, -32'sd1, 32'sd1, 1'b0, 1'b1);
        add_row(fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MIN, 32'sh1234_5678, 1'b1, 1'b1);
        add_row(-32'sh0005_0000, 32'sd7, 32'sd0, 1'b0, 1'b1);
        add_row(32'sd3, 32'sd4, 32'sd5, 1'b0, 1'b0);
        add_row(fpcs_pkg::COORD_MIN, 32'sd0, fpcs_pkg::COORD_MAX, 1'b1, 1'b0);
        add_row(fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MIN, 1'b0, 1'b1);
        add_row(fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MAX, 1'b0, 1'b0);
        add_row(fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MAX, 1'b0, 1'b0);
        add_row(fpcs_pkg::COORD_MIN, fpcs_pkg::COORD_MAX, fpcs_pkg::COORD_MIN, 1'b1, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1);
        add_row(-32'sd16, 32'sd16, -32'sd1, 1'b0, 1'b0);
        add_row(32'sd15, -32'sd15, 32'sd1, 1'b0, 1'b0);
        add_row(-32'sd1, 32'sd1, 32'sd0, 1'b0, 1'b0);
        add_row(32'sh0001_0000, -32'sh0001_8000, 32'sh7fff_0000, 1'b0, 1'b0);
        add_row(-32'sh4000_0000, 32'sh5555_5555, -32'sh2aaa_aaab, 1'b1, 1'b0);

        foreach (directed_rows[k]) begin
            send_vertex(directed_rows[k].vin, directed_rows[k].typed, directed_rows[k].want);
            idle_sender();
        end
        drain_sender();

        random_sent = 0;
        while (random_sent < RANDOM_VERTICES) begin
            len = pick_length();
            for (int k = 0; k < len; k++) begin
                v.coord_x      = random_coord();
                v.coord_y      = random_coord();
                v.coord_z      = random_coord();
                v.final_vertex = (k == len - 1);
                send_vertex(v, 1'b0, '0);
                random_sent++;
                if (random_sent == 40) begin
                    hold_off_req = 1'b1;
                end
                if (random_sent == 110) begin
                    drain_sender();
                end else begin
                    idle_sender();
                end
            end
        end

        i_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d vertices in %0d polylines; checked %0d points.",
                 vertices_sent, polylines_sent, points_seen);
        $display("Inserted points: %0d, with saturated x: %0d; failures: %0d.",
                 inserted_seen, saturated_seen, failures);
        if (failures == 0) begin
            $display("four_point_curve_subdivision_test: PASS");
        end else begin
            $display("four_point_curve_subdivision_test: FAIL");
        end
        $finish;
    end

endmodule
